>>> rtl/assert_macros.svh
// Assertion macros shared by the checker modules of the block.
// No dependencies; every macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property, disabled while reset is asserted.
`define BMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Concurrent check that a condition leads to a consequence in the next cycle.
`define BMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bmf_pkg.sv
// Package of the block median filter: sizes, types and the cell control struct.
// No dependencies.
package bmf_pkg;

  localparam int WINDOW      = 30;
  localparam int SAMPLE_BITS = 12;
  localparam int MEDIAN_IDX  = (WINDOW - 1) / 2;
  localparam int CNT_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // Broadcast to every cell of the sort row.
  typedef struct packed {
    logic    en;      // a sample beat is taken this cycle
    sample_t sample;  // the sample being inserted
  } bmf_ctl_t;

endpackage

>>> rtl/bmf_cell.sv
// One slot of the insertion-sort row: holds one sample of the sorted window.
// Depends on bmf_pkg.
module bmf_cell (
  input  logic              clk_i,
  input  bmf_pkg::bmf_ctl_t ctl_i,
  input  logic              empty_i,     // slot lies beyond the current fill
  input  bmf_pkg::sample_t  left_val_i,  // value of the left neighbor
  input  logic              left_ins_i,  // left neighbor hands its value right
  output bmf_pkg::sample_t  val_o,
  output logic              ins_o,       // new sample goes at or left of here
  output bmf_pkg::sample_t  val_next_o
);
  import bmf_pkg::*;

  sample_t val_q, val_d;

  // An empty slot counts as larger than any sample; ties insert after.
  assign ins_o = empty_i || (ctl_i.sample < val_q);

  // Keep, take the sample, or take the neighbor's value as the row shifts.
  always_comb begin
    if (!ins_o) begin
      val_d = val_q;
    end else if (left_ins_i) begin
      val_d = left_val_i;
    end else begin
      val_d = ctl_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      val_q <= val_d;
    end
  end

  assign val_o      = val_q;
  assign val_next_o = val_d;

endmodule

>>> rtl/bmf_chain.sv
// Row of sort cells kept in ascending order; taps the median slot.
// Depends on bmf_pkg and bmf_cell.
module bmf_chain (
  input  logic              clk_i,
  input  bmf_pkg::bmf_ctl_t ctl_i,
  input  bmf_pkg::cnt_t     count_i,   // samples already in the window
  output bmf_pkg::sample_t  median_o   // median slot after this insertion
);
  import bmf_pkg::*;

  sample_t val      [WINDOW];
  sample_t val_next [WINDOW];
  logic    ins      [WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic    empty;
    sample_t left_val;
    logic    left_ins;

    // Slots at or past the fill count hold nothing of this window.
    assign empty = (count_i <= cnt_t'(i));

    if (i == 0) begin : g_head
      assign left_val = '0;
      assign left_ins = 1'b0;
    end else begin : g_body
      assign left_val = val[i-1];
      assign left_ins = ins[i-1];
    end

    bmf_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl_i),
      .empty_i    (empty),
      .left_val_i (left_val),
      .left_ins_i (left_ins),
      .val_o      (val[i]),
      .ins_o      (ins[i]),
      .val_next_o (val_next[i])
    );
  end

  assign median_o = val_next[MEDIAN_IDX];

endmodule

>>> rtl/block_median_filter_top.sv
// Top level of the block median filter: stream ports, fill count, result register.
// Depends on bmf_pkg and bmf_chain.

// Samples are grouped into back-to-back windows of WINDOW beats (30) with no
// overlap; each window yields one beat carrying its lower median (sorted index
// (WINDOW-1)/2), and no other sample yields anything. One sample is taken per
// clock cycle while the closing sample is not stalled: each beat is inserted
// into a row of WINDOW sort cells, and the median beat shows on the master side
// in the cycle after the last sample of its window. The result sits in an output
// register; samples that do not close a window are still taken while it waits,
// only the closing sample stalls until the result slot is free.
module block_median_filter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [bmf_pkg::TDATA_W-1:0]  s_axis_tdata_i,   // [11:0] sample
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [bmf_pkg::TDATA_W-1:0]  m_axis_tdata_o    // [11:0] median
);
  import bmf_pkg::*;

  cnt_t     count_q, count_d;
  logic     out_vld_q, out_vld_d;
  sample_t  out_dat_q;
  sample_t  median;
  logic     last;
  logic     beat;
  bmf_ctl_t ctl;

  // Closing sample needs a free result slot; others always go in.
  assign last            = (count_q == cnt_t'(WINDOW - 1));
  assign s_axis_tready_o = !last || !out_vld_q || m_axis_tready_i;
  assign beat            = s_axis_tvalid_i && s_axis_tready_o;

  assign ctl.en     = beat;
  assign ctl.sample = s_axis_tdata_i[SAMPLE_BITS-1:0];

  bmf_chain u_chain (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .count_i  (count_q),
    .median_o (median)
  );

  // Fill count and result valid.
  always_comb begin
    count_d   = count_q;
    out_vld_d = out_vld_q;
    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    if (beat) begin
      if (last) begin
        count_d   = '0;
        out_vld_d = 1'b1;
      end else begin
        count_d = count_q + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (beat && last) begin
      out_dat_q <= median;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = TDATA_W'(out_dat_q);

endmodule

>>> rtl/bmf_checker.sv
// Port-level checks of the block median filter, bound to the top level.
// Depends on bmf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [bmf_pkg::TDATA_W-1:0]  m_axis_tdata_o    // [11:0] median
);
  import bmf_pkg::*;

  cnt_t cnt_q;
  logic in_beat;
  logic closing;
  logic window_end;
  logic out_stall;

  assign in_beat    = s_axis_tvalid_i && s_axis_tready_o;
  assign closing    = (cnt_q == cnt_t'(WINDOW - 1));
  assign window_end = in_beat && closing;
  assign out_stall  = m_axis_tvalid_o && !m_axis_tready_i;

  // Independent count of sample beats within the window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_beat) begin
      cnt_q <= closing ? '0 : cnt_q + cnt_t'(1);
    end
  end

  `BMF_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o, "median beat dropped while stalled")
  `BMF_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata_o), "median changed in stall")
  `BMF_ASSERT_NEXT(a_window_result, window_end, m_axis_tvalid_o, "no median after closing sample")
  `BMF_ASSERT(a_no_overrun, (out_stall && closing) |-> !s_axis_tready_o, "median overrun")
  `BMF_ASSERT(a_no_spurious, $rose(m_axis_tvalid_o) |-> $past(window_end), "spurious median")

endmodule

bind block_median_filter_top bmf_checker u_bmf_checker (.*);

>>> tb/tb_top.sv
// Self-checking bench for block_median_filter_top: drives 30-sample windows over the stream
// ports and checks every median beat against typed-in values or an in-bench window sorter.
// Depends on bmf_pkg and the RTL of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmf_pkg::*;

  localparam int PAD_W = TDATA_W - SAMPLE_BITS;

  // Directed window shapes
  typedef enum int {PAT_FLAT, PAT_RAMP_UP, PAT_RAMP_DOWN, PAT_SPLIT, PAT_ALTERNATE} pattern_e;
  // Random window content styles
  typedef enum int {STY_FULL, STY_BAND, STY_EXTREME, STY_RAMP} style_e;

  typedef struct {
    pattern_e         pat;
    sample_t          a;
    sample_t          b;
    int               n;      // split point for PAT_SPLIT
    logic [PAD_W-1:0] pad;    // bits above the sample, must be ignored
    bit               known;  // median typed in below
    sample_t          exp;
  } win_row_t;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_valid = 1'b0;
  logic [TDATA_W-1:0] s_data = '0;
  logic               m_ready = 1'b0;
  logic               s_axis_tready_o;
  logic               m_axis_tvalid_o;
  logic [TDATA_W-1:0] m_axis_tdata_o;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;

  // Expected medians, oldest first
  sample_t median_q[$];
  sample_t expected_median;

  // Predictor copy of the window
  sample_t window_buf[WINDOW];
  int      fill_cnt = 0;

  win_row_t dir_rows[0:9];

  always #5 clk_i = ~clk_i;

  block_median_filter_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Lower median of the held window: insertion sort, pick index MEDIAN_IDX
  function automatic sample_t lower_median_of();
    sample_t sorted[WINDOW];
    sample_t v;
    int      pos;
    for (int k = 0; k < WINDOW; k++) begin
      v   = window_buf[k];
      pos = k;
      while (pos > 0 && sorted[pos-1] > v) begin
        sorted[pos] = sorted[pos-1];
        pos--;
      end
      sorted[pos] = v;
    end
    return sorted[MEDIAN_IDX];
  endfunction

  // Predictor step for one accepted sample
  task automatic absorb_sample(input sample_t v, output bit closed, output sample_t med);
    closed = 1'b0;
    med    = '0;
    if (fill_cnt >= WINDOW) fill_cnt = 0;
    window_buf[fill_cnt] = v;
    fill_cnt++;
    if (fill_cnt == WINDOW) begin
      closed   = 1'b1;
      med      = lower_median_of();
      fill_cnt = 0;
    end
  endtask

  // Offer one sample beat, with random idle cycles ahead of it
  task automatic push_sample(input logic [TDATA_W-1:0] d, output bit closed,
                             output sample_t med);
    while (roll(send_idle_pct)) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    absorb_sample(d[SAMPLE_BITS-1:0], closed, med);
  endtask

  function automatic sample_t pattern_value(win_row_t r, int k);
    case (r.pat)
      PAT_FLAT:      return r.a;
      PAT_RAMP_UP:   return r.a + sample_t'(k) * r.b;
      PAT_RAMP_DOWN: return r.a - sample_t'(k) * r.b;
      PAT_SPLIT:     return (k < r.n) ? r.a : r.b;
      default:       return k[0] ? r.b : r.a;
    endcase
  endfunction

  function automatic sample_t random_sample(style_e sty, sample_t base, int k);
    case (sty)
      STY_FULL:    return sample_t'($urandom);
      STY_BAND:    return base + sample_t'($urandom_range(0, 3));
      STY_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return sample_t'(1);
          2:       return {{(SAMPLE_BITS-1){1'b1}}, 1'b0};
          default: return '1;
        endcase
      end
      default:     return base + sample_t'(k * 3) + sample_t'($urandom_range(0, 2));
    endcase
  endfunction

  // One full random window; expectation comes from the predictor
  task automatic send_random_window();
    style_e  sty;
    sample_t base;
    sample_t med;
    bit      closed;
    sty  = style_e'($urandom_range(0, 3));
    base = sample_t'($urandom);
    for (int k = 0; k < WINDOW; k++) begin
      push_sample({PAD_W'($urandom), random_sample(sty, base, k)}, closed, med);
      if (closed) median_q.push_back(med);
    end
  endtask

  // Hold the sender until every expected median has come out
  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Result side: compare each median beat, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (m_axis_tvalid_o && m_ready) begin
        if (median_q.size() == 0) begin
          $display("%0t: unexpected median beat, expected none, got %h", $time,
                   m_axis_tdata_o);
          fail_count++;
        end else begin
          expected_median = median_q.pop_front();
          if (m_axis_tdata_o !== {{PAD_W{1'b0}}, expected_median}) begin
            $display("%0t: median mismatch, expected %h, got %h", $time,
                     {{PAD_W{1'b0}}, expected_median}, m_axis_tdata_o);
            fail_count++;
          end
        end
      end
      m_ready <= !roll(recv_stall_pct);
    end
  end

  // Stimulus
  initial begin
    sample_t med;
    bit      closed;
    int      tail;

    // pat, a, b, n, pad, known, exp
    dir_rows[0] = '{PAT_FLAT,      12'd0,    12'd0,    0,  4'h0, 1'b1, 12'd0};
    dir_rows[1] = '{PAT_FLAT,      12'd4095, 12'd0,    0,  4'h0, 1'b1, 12'd4095};
    dir_rows[2] = '{PAT_FLAT,      12'd2730, 12'd0,    0,  4'hF, 1'b1, 12'd2730};
    dir_rows[3] = '{PAT_RAMP_UP,   12'd0,    12'd1,    0,  4'h0, 1'b1, 12'd14};
    dir_rows[4] = '{PAT_RAMP_DOWN, 12'd4095, 12'd1,    0,  4'h5, 1'b1, 12'd4080};
    dir_rows[5] = '{PAT_SPLIT,     12'd0,    12'd4095, 15, 4'h0, 1'b1, 12'd0};
    dir_rows[6] = '{PAT_SPLIT,     12'd0,    12'd4095, 14, 4'hA, 1'b1, 12'd4095};
    dir_rows[7] = '{PAT_ALTERNATE, 12'd4095, 12'd0,    0,  4'h0, 1'b1, 12'd0};
    dir_rows[8] = '{PAT_RAMP_UP,   12'd4000, 12'd7,    0,  4'h3, 1'b0, 12'd0};
    dir_rows[9] = '{PAT_SPLIT,     12'd4094, 12'd1,    16, 4'hC, 1'b0, 12'd0};

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed windows, no idling
    foreach (dir_rows[r]) begin
      for (int k = 0; k < WINDOW; k++) begin
        push_sample({dir_rows[r].pad, pattern_value(dir_rows[r], k)}, closed, med);
        if (closed) median_q.push_back(dir_rows[r].known ? dir_rows[r].exp : med);
      end
    end
    drain_results();

    // Random windows under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int w = 0; w < 4; w++) begin
        send_random_window();
        if (w == 1) drain_results();
      end
      drain_results();
    end

    // Unfinished window at the end must not produce a beat
    tail = $urandom_range(1, WINDOW - 1);
    for (int k = 0; k < tail; k++) begin
      push_sample(TDATA_W'($urandom), closed, med);
      if (closed) median_q.push_back(med);
    end
    s_valid <= 1'b0;

    @(posedge clk_i);
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && median_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
